### hdl/hptl_pkg.sv
// Shared constants, types and hash functions for the hashed path table lookup.
`default_nettype none
package hptl_pkg;

  localparam int unsigned TABLE_SLOTS_DEF = 1024;

  localparam int unsigned FOLD_SHL = 10;
  localparam int unsigned FOLD_SHR = 6;
  localparam int unsigned FIN_SHL1 = 3;
  localparam int unsigned FIN_SHR  = 11;
  localparam int unsigned FIN_SHL2 = 15;

  localparam logic REG_DATA_BASE    = 1'b0;
  localparam logic REG_THUMB_STRIDE = 1'b1;

  localparam logic MODE_TABLE_WRITE = 1'b0;
  localparam logic MODE_PATH_BYTE   = 1'b1;

  typedef struct packed {
    logic        we;
    logic [31:0] key;
    logic [15:0] idx;
  } tbl_wr_t;

  function automatic logic [31:0] fold_byte(input logic [31:0] h, input logic [7:0] b);
    logic [31:0] t;
    t = h + {24'd0, b};
    t = t + (t << FOLD_SHL);
    t = t ^ (t >> FOLD_SHR);
    return t;
  endfunction

  function automatic logic [31:0] finish_hash(input logic [31:0] h);
    logic [31:0] t;
    t = h + (h << FIN_SHL1);
    t = t ^ (t >> FIN_SHR);
    t = t + (t << FIN_SHL2);
    return t;
  endfunction

endpackage
`default_nettype wire

### hdl/hptl_table.sv
// Key and index tables: one write port, one registered read port.
`default_nettype none
module hptl_table #(
  parameter int unsigned TABLE_SLOTS = hptl_pkg::TABLE_SLOTS_DEF,
  localparam int unsigned SLOT_W = $clog2(TABLE_SLOTS)
) (
  input  wire                  clk_i,
  input  hptl_pkg::tbl_wr_t    wr_i,
  input  wire  [SLOT_W-1:0]    waddr_i,
  input  wire                  rd_en_i,
  input  wire  [SLOT_W-1:0]    raddr_i,
  output logic [31:0]          rd_key_o,
  output logic [15:0]          rd_idx_o
);

  logic [31:0] key_mem [TABLE_SLOTS];
  logic [15:0] idx_mem [TABLE_SLOTS];

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      key_mem[waddr_i] <= wr_i.key;
    end
    if (rd_en_i) begin
      rd_key_o <= key_mem[raddr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      idx_mem[waddr_i] <= wr_i.idx;
    end
    if (rd_en_i) begin
      rd_idx_o <= idx_mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

### hdl/hashed_path_table_lookup.sv
// Top level: path hash, key remainder, linear probe and offset computation.
//
//  channel   direction  handshake                 payload
//  request   in         start_i high, busy_o low  mode, byte_value, last, slot, entry_key,
//                                                 entry_index
//  result    out        done_o strobe, 1 cycle    found, path_key, thumb_index, byte_offset
//  config    in         APB write, pready high    data_base at 0, thumb_stride at 4
//
// A table write or a non-final path byte leaves the block idle and busy_o stays low.
// A final byte holds busy_o high through the finalise step, the remainder (reciprocal
// multiply, subtract, correct), a probe of n table reads, then multiply and add; a miss
// reads every slot and drains the last read in place of the multiply. done_o pulses
// after the add, with n from 1 to TABLE_SLOTS. The probe is set by the single read
// port of the tables. Reset clears control state and the hash; the tables are not
// cleared. done_o cannot be stalled.
`default_nettype none
module hashed_path_table_lookup #(
  parameter int unsigned TABLE_SLOTS = hptl_pkg::TABLE_SLOTS_DEF
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         start_i,
  output logic        busy_o,
  input  wire         mode_i,
  input  wire  [7:0]  byte_value_i,
  input  wire         last_i,
  input  wire  [9:0]  slot_i,
  input  wire  [31:0] entry_key_i,
  input  wire  [15:0] entry_index_i,
  output logic        done_o,
  output logic        found_o,
  output logic [31:0] path_key_o,
  output logic [15:0] thumb_index_o,
  output logic [31:0] byte_offset_o,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [2:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned SLOT_W = $clog2(TABLE_SLOTS);
  localparam int unsigned CNT_W  = SLOT_W + 1;
  localparam logic [CNT_W-1:0]  SLOTS_C = CNT_W'(TABLE_SLOTS);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SLOTS - 1);
  localparam logic [31:0]       SLOTS_32 = 32'(TABLE_SLOTS);
  localparam logic [31:0]       RECIP_C = 32'((64'd1 << 32) / 64'(TABLE_SLOTS));

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_FIN   = 8'b00000010,
    S_QUO   = 8'b00000100,
    S_REM   = 8'b00001000,
    S_POS   = 8'b00010000,
    S_PROBE = 8'b00100000,
    S_MUL   = 8'b01000000,
    S_ADD   = 8'b10000000
  } state_e;

  state_e state_q, state_d;

  logic [31:0]       base_q;
  logic [23:0]       stride_q;
  logic [31:0]       hash_q, hash_d;
  logic [31:0]       key_q, key_d;
  logic [31:0]       quo_q, quo_d;
  logic [63:0]       quo_full;
  logic [31:0]       quo_s;
  logic [31:0]       rem_q, rem_d;
  logic [SLOT_W-1:0] rd_pos_q, rd_pos_d;
  logic [CNT_W-1:0]  rd_cnt_q, rd_cnt_d;
  logic              pv_q, pv_d;
  logic              issue;
  logic              hit_q, hit_d;
  logic [15:0]       idx_q, idx_d;
  logic [31:0]       prod_q, prod_d;
  logic [39:0]       prod_full;
  logic              done_q, done_d;
  logic              found_q, found_d;
  logic [15:0]       tidx_q, tidx_d;
  logic [31:0]       off_q, off_d;
  logic              accept;
  logic              cfg_we;
  logic [31:0]       rd_key;
  logic [15:0]       rd_idx;
  hptl_pkg::tbl_wr_t tbl_wr;

  assign accept = start_i && (state_q == S_IDLE);
  assign busy_o = (state_q != S_IDLE);

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_comb begin
    unique case (paddr[2])
      hptl_pkg::REG_DATA_BASE:    prdata = base_q;
      hptl_pkg::REG_THUMB_STRIDE: prdata = {8'd0, stride_q};
      default:                    prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q   <= 32'd0;
      stride_q <= 24'd1;
    end else if (cfg_we) begin
      unique case (paddr[2])
        hptl_pkg::REG_DATA_BASE:    base_q   <= pwdata;
        hptl_pkg::REG_THUMB_STRIDE: stride_q <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    tbl_wr.we  = accept && (mode_i == hptl_pkg::MODE_TABLE_WRITE)
                 && (32'(slot_i) < 32'(TABLE_SLOTS));
    tbl_wr.key = entry_key_i;
    tbl_wr.idx = entry_index_i;
  end

  hptl_table #(
    .TABLE_SLOTS(TABLE_SLOTS)
  ) u_table (
    .clk_i    (clk_i),
    .wr_i     (tbl_wr),
    .waddr_i  (SLOT_W'(slot_i)),
    .rd_en_i  (issue),
    .raddr_i  (rd_pos_q),
    .rd_key_o (rd_key),
    .rd_idx_o (rd_idx)
  );

  assign quo_full  = key_q * RECIP_C;
  assign quo_s     = 32'(quo_q * SLOTS_32);
  assign prod_full = idx_q * stride_q;
  assign issue     = (state_q == S_PROBE) && (rd_cnt_q < SLOTS_C);

  always_comb begin
    state_d   = state_q;
    hash_d    = hash_q;
    key_d     = key_q;
    quo_d     = quo_q;
    rem_d     = rem_q;
    rd_pos_d  = rd_pos_q;
    rd_cnt_d  = rd_cnt_q;
    pv_d      = 1'b0;
    hit_d     = hit_q;
    idx_d     = idx_q;
    prod_d    = prod_q;
    done_d    = 1'b0;
    found_d   = found_q;
    tidx_d    = tidx_q;
    off_d     = off_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept && (mode_i == hptl_pkg::MODE_PATH_BYTE)) begin
          if (last_i) begin
            hash_d  = 32'd0;
            key_d   = hptl_pkg::fold_byte(hash_q, byte_value_i);
            state_d = S_FIN;
          end else begin
            hash_d = hptl_pkg::fold_byte(hash_q, byte_value_i);
          end
        end
      end
      S_FIN: begin
        key_d   = hptl_pkg::finish_hash(key_q);
        state_d = S_QUO;
      end
      S_QUO: begin
        quo_d   = quo_full[63:32];
        state_d = S_REM;
      end
      S_REM: begin
        rem_d   = key_q - quo_s;
        state_d = S_POS;
      end
      S_POS: begin
        rd_pos_d = SLOT_W'((rem_q >= SLOTS_32) ? rem_q - SLOTS_32 : rem_q);
        rd_cnt_d = '0;
        state_d  = S_PROBE;
      end
      S_PROBE: begin
        if (issue) begin
          rd_cnt_d = rd_cnt_q + 1'b1;
          rd_pos_d = (rd_pos_q == LAST_SLOT) ? '0 : rd_pos_q + 1'b1;
          pv_d     = 1'b1;
        end
        if (pv_q && (rd_key == key_q)) begin
          hit_d   = 1'b1;
          idx_d   = rd_idx;
          pv_d    = 1'b0;
          state_d = S_MUL;
        end else if (!pv_q && !issue) begin
          hit_d   = 1'b0;
          idx_d   = 16'd0;
          state_d = S_ADD;
        end
      end
      S_MUL: begin
        prod_d  = prod_full[31:0];
        state_d = S_ADD;
      end
      S_ADD: begin
        found_d = hit_q;
        tidx_d  = hit_q ? idx_q : 16'd0;
        off_d   = hit_q ? base_q + prod_q : 32'd0;
        done_d  = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      hash_q   <= 32'd0;
      pv_q     <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      hash_q   <= hash_d;
      pv_q     <= pv_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q     <= key_d;
    quo_q     <= quo_d;
    rem_q     <= rem_d;
    rd_pos_q  <= rd_pos_d;
    rd_cnt_q  <= rd_cnt_d;
    hit_q     <= hit_d;
    idx_q     <= idx_d;
    prod_q    <= prod_d;
    found_q   <= found_d;
    tidx_q    <= tidx_d;
    off_q     <= off_d;
  end

  assign done_o        = done_q;
  assign found_o       = found_q;
  assign path_key_o    = key_q;
  assign thumb_index_o = tidx_q;
  assign byte_offset_o = off_q;

endmodule
`default_nettype wire
